>>> design/rfd_pkg.sv
// Shared types and constants of the frame deframer.
package rfd_pkg;

  // Byte region labels.
  localparam logic [1:0] REGION_HEADER  = 2'd0;
  localparam logic [1:0] REGION_META    = 2'd1;
  localparam logic [1:0] REGION_PAYLOAD = 2'd2;

  // Header error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_MAGIC     = 2'd1;
  localparam logic [1:0] ERR_OVERSIZE  = 2'd2;
  localparam logic [1:0] ERR_BAD_LEN   = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY_BYTES = 8'd1;
  localparam int unsigned CFG_DATA_W = 32;

  // Fixed header layout.
  localparam int unsigned HDR_STORE_BYTES = 8;
  localparam int unsigned META_HI_IDX     = 8;
  localparam int unsigned META_LO_IDX     = 9;

  // Queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [1:0]  region;
    logic        header_done;
    logic [15:0] meta_length;
    logic [31:0] body_length;
    logic        frame_done;
    logic [1:0]  error_code;
  } rfd_item_t;

endpackage

>>> design/rfd_ifs.sv
// Channel interfaces of the frame deframer: byte input, result output, config writes.
interface rfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface rfd_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic [1:0]  region;
  logic        header_done;
  logic [15:0] meta_length;
  logic [31:0] payload_length;
  logic        frame_done;
  logic [1:0]  error_code;
  modport source (output valid, output byte_out, output region, output header_done,
                  output meta_length, output payload_length, output frame_done,
                  output error_code, input ready);
  modport sink (input valid, input byte_out, input region, input header_done,
                input meta_length, input payload_length, input frame_done,
                input error_code, output ready);
endinterface

interface rfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> design/rfd_front.sv
// Front end: accepts stream bytes, tracks header and body phase, checks the header.
module rfd_front #(
  parameter int unsigned HeaderBytes = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  rfd_byte_if.sink           in_i,
  input  logic [15:0]        magic_word_i,
  input  logic [31:0]        max_body_bytes_i,
  output rfd_pkg::rfd_item_t item_o,
  output logic               item_valid_o,
  input  logic               item_ready_i
);
  import rfd_pkg::*;

  localparam int unsigned HdrCntW = $clog2(HeaderBytes);
  localparam logic [HdrCntW-1:0] LastIdx   = HdrCntW'(HeaderBytes - 1);
  localparam logic [HdrCntW-1:0] StoreIdx  = HdrCntW'(HDR_STORE_BYTES);
  localparam logic [HdrCntW-1:0] MetaHiIdx = HdrCntW'(META_HI_IDX);
  localparam logic [HdrCntW-1:0] MetaLoIdx = HdrCntW'(META_LO_IDX);
  localparam logic [31:0] HdrLen   = 32'(HeaderBytes);
  localparam logic [31:0] HdrLenP1 = 32'(HeaderBytes + 1);

  logic               acc;
  logic [7:0]         b;
  logic [HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic               body_phase_q, body_phase_d;
  logic [31:0]        body_cnt_q, body_cnt_d;
  logic [31:0]        body_last_q, body_last_d;
  logic [63:0]        header_q, header_d;
  logic [15:0]        meta_q, meta_d;
  logic [31:0]        body_q, body_d;
  logic [31:0]        body_m1_q, body_m1_d;
  logic               short_q, short_d;
  logic               bad_magic_q, bad_magic_d;
  rfd_item_t          item;

  assign acc          = in_i.valid && item_ready_i;
  assign in_i.ready   = item_ready_i;
  assign item_valid_o = in_i.valid;
  assign item_o       = item;
  assign b            = in_i.data_byte;

  always_comb begin
    hdr_cnt_d    = hdr_cnt_q;
    body_phase_d = body_phase_q;
    body_cnt_d   = body_cnt_q;
    body_last_d  = body_last_q;
    header_d     = header_q;
    meta_d       = meta_q;
    body_d       = body_q;
    body_m1_d    = body_m1_q;
    short_d      = short_q;
    bad_magic_d  = bad_magic_q;

    item             = '0;
    item.byte_out    = b;
    item.region      = REGION_HEADER;
    item.error_code  = ERR_NONE;

    if (!body_phase_q) begin
      if (hdr_cnt_q < StoreIdx) begin
        header_d = {header_q[55:0], b};
      end
      if (hdr_cnt_q == MetaHiIdx || hdr_cnt_q == MetaLoIdx) begin
        meta_d = {meta_q[7:0], b};
      end
      // Once the first eight bytes are in, precompute the body length and magic checks.
      if (hdr_cnt_q == StoreIdx) begin
        body_d      = header_q[31:0] - HdrLen;
        body_m1_d   = header_q[31:0] - HdrLenP1;
        short_d     = header_q[31:0] < HdrLen;
        bad_magic_d = (header_q[63:48] != magic_word_i) || (header_q[47:32] != 16'd0);
      end
      if (hdr_cnt_q == LastIdx) begin
        hdr_cnt_d = '0;
        priority if (bad_magic_q) begin
          item.error_code = ERR_MAGIC;
        end else if (short_q || body_q >= max_body_bytes_i) begin
          item.error_code = ERR_OVERSIZE;
        end else if ({16'd0, meta_d} > body_q) begin
          item.error_code = ERR_BAD_LEN;
        end else begin
          item.header_done = 1'b1;
          item.meta_length = meta_d;
          item.body_length = body_q;
          if (body_q == 32'd0) begin
            item.frame_done = 1'b1;
          end else begin
            body_phase_d = 1'b1;
            body_cnt_d   = 32'd0;
            body_last_d  = body_m1_q;
          end
        end
      end else begin
        hdr_cnt_d = hdr_cnt_q + 1'b1;
      end
    end else begin
      item.region = (body_cnt_q < {16'd0, meta_q}) ? REGION_META : REGION_PAYLOAD;
      if (body_cnt_q == body_last_q) begin
        item.frame_done = 1'b1;
        body_phase_d    = 1'b0;
      end else begin
        body_cnt_d = body_cnt_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q    <= '0;
      body_phase_q <= 1'b0;
    end else if (acc) begin
      hdr_cnt_q    <= hdr_cnt_d;
      body_phase_q <= body_phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      body_cnt_q  <= body_cnt_d;
      body_last_q <= body_last_d;
      header_q    <= header_d;
      meta_q      <= meta_d;
      body_q      <= body_d;
      body_m1_q   <= body_m1_d;
      short_q     <= short_d;
      bad_magic_q <= bad_magic_d;
    end
  end

endmodule

>>> design/rfd_queue.sv
// Two-entry queue that decouples the front end from the output stage.
module rfd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  rfd_pkg::rfd_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output rfd_pkg::rfd_item_t pop_item_o
);
  import rfd_pkg::*;

  rfd_item_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q, count_d;
  logic              push, pop;

  assign push_ready_o = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    unique case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> design/rfd_back.sv
// Back end: computes the payload length and holds the result word for the receiver.
module rfd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  rfd_pkg::rfd_item_t item_i,
  rfd_res_if.source          out_o
);
  import rfd_pkg::*;

  logic        out_valid_q;
  logic        load;
  logic [7:0]  byte_q;
  logic [1:0]  region_q;
  logic        hdone_q;
  logic [15:0] meta_q;
  logic [31:0] plen_q, plen_d;
  logic        fdone_q;
  logic [1:0]  err_q;

  assign item_ready_o = !out_valid_q || out_o.ready;
  assign load         = item_valid_i && item_ready_o;
  // Both lengths are zero on words without header_done, so this yields zero there.
  assign plen_d       = item_i.body_length - {16'd0, item_i.meta_length};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_ready_o) begin
      out_valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= item_i.byte_out;
      region_q <= item_i.region;
      hdone_q  <= item_i.header_done;
      meta_q   <= item_i.meta_length;
      plen_q   <= plen_d;
      fdone_q  <= item_i.frame_done;
      err_q    <= item_i.error_code;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.byte_out       = byte_q;
  assign out_o.region         = region_q;
  assign out_o.header_done    = hdone_q;
  assign out_o.meta_length    = meta_q;
  assign out_o.payload_length = plen_q;
  assign out_o.frame_done     = fdone_q;
  assign out_o.error_code     = err_q;

endmodule

>>> design/rpc_frame_deframer_top.sv
// Top level of the length-prefixed frame deframer.
//
// The block takes one stream byte per word on in_i and returns exactly one
// result word per byte on out_o: the byte, its region (header, metadata or
// payload), and on the last header byte the check result with the metadata
// and payload lengths. The last byte of a good frame carries frame_done.
// A header that fails a check reports its error code and the next byte
// starts a new header. Configuration writes arrive on cfg_i, are always
// taken, and must only be issued while no byte is in flight; an unknown
// index is ignored.
//
// Throughput is one word per cycle while the receiver keeps out_o.ready
// high; the front end makes each byte decision with counter compares. A
// byte accepted on in_i is written into the two-entry queue and then into
// the output register. When the receiver stalls, the output register
// holds its word, the queue fills, and in_i.ready drops once both queue
// entries are taken. Reset empties the queue and the output register, puts
// the block in the header phase and loads the default register values
// (magic word zero, body limit all ones).
module rpc_frame_deframer_top #(
  parameter int unsigned HeaderBytes = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rfd_byte_if.sink  in_i,
  rfd_res_if.source out_o,
  rfd_cfg_if.sink   cfg_i
);
  import rfd_pkg::*;

  logic [15:0] magic_word_q;
  logic [31:0] max_body_q;
  rfd_item_t   front_item, q_item;
  logic        front_valid, front_ready;
  logic        q_valid, q_ready;

  // Configuration registers; writes are always accepted.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_word_q <= 16'd0;
      max_body_q   <= 32'hFFFF_FFFF;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_MAGIC_WORD) begin
        magic_word_q <= cfg_i.wdata[15:0];
      end
      if (cfg_i.index == CFG_MAX_BODY_BYTES) begin
        max_body_q <= cfg_i.wdata;
      end
    end
  end

  rfd_front #(
    .HeaderBytes(HeaderBytes)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_i            (in_i),
    .magic_word_i    (magic_word_q),
    .max_body_bytes_i(max_body_q),
    .item_o          (front_item),
    .item_valid_o    (front_valid),
    .item_ready_i    (front_ready)
  );

  rfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(front_valid),
    .push_ready_o(front_ready),
    .push_item_i (front_item),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_item_o  (q_item)
  );

  rfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(q_valid),
    .item_ready_o(q_ready),
    .item_i      (q_item),
    .out_o       (out_o)
  );

  // A word taken from the queue is presented on the output in the next cycle.
  a_pop_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && q_ready) |=> out_o.valid)
    else $error("queued word did not reach the output register");

  // A passing header is reported only on a header byte and never with an error.
  a_hdone_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.header_done) |->
      (out_o.region == REGION_HEADER && out_o.error_code == ERR_NONE))
    else $error("header_done on a non-header byte or with an error");

  // A frame can end on a header byte only when that header passed.
  a_empty_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.frame_done && out_o.region == REGION_HEADER) |->
      (out_o.header_done && out_o.payload_length == 32'd0 &&
       out_o.meta_length == 16'd0))
    else $error("frame_done on a header byte without an empty passing frame");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench of the frame deframer: framed byte stream in, predicted words checked out.
module tb;
  import rfd_pkg::*;

  localparam int unsigned HDR_LEN     = 16;
  localparam int unsigned TIMEOUT_TU  = 2000000;
  localparam int unsigned MAX_PRINTED = 100;

  // One result word as the block reports it.
  typedef struct packed {
    logic [7:0]  byte_out;
    logic [1:0]  region;
    logic        header_done;
    logic [15:0] meta_length;
    logic [31:0] payload_length;
    logic        frame_done;
    logic [1:0]  error_code;
  } res_word_t;

  logic clk;
  logic rst_n;

  rfd_byte_if in_if ();
  rfd_res_if  out_if ();
  rfd_cfg_if  cfg_if ();

  rpc_frame_deframer_top #(
    .HeaderBytes(HDR_LEN)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Bytes waiting to be sent and words predicted but not yet seen.
  logic [7:0] byte_stream[$];
  res_word_t  predicted_words[$];

  // Register copies and deframer state of the predictor.
  logic [15:0] cfg_magic_q    = '0;
  logic [31:0] cfg_max_body_q = '1;
  logic [31:0] hdr_pos        = '0;
  logic [63:0] hdr_shift      = '0;
  logic [15:0] meta_len_q     = '0;
  logic [31:0] body_len_q     = '0;

  // Handshakes seen at the last rising edge, used by the drivers at the falling edge.
  bit in_fire;
  bit out_fire;
  int in_gap;
  int out_stall;
  bit in_calm;
  bit out_calm;

  int mismatches;
  int words_checked;
  int frames_done;
  int rej_magic;
  int rej_oversize;
  int rej_len;
  int bytes_queued;
  int settings_run;
  res_word_t want;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_v);
    if (got !== exp_v)
      report_mismatch($sformatf("word %0d %s: got %0h, want %0h",
                                words_checked, name, got, exp_v));
  endtask

  // Advances the deframer state by one byte and returns the word it should produce.
  function automatic res_word_t deframe_byte(input logic [7:0] b);
    res_word_t   r;
    logic [15:0] magic;
    logic [15:0] types;
    logic [31:0] total;
    logic [31:0] body;
    r          = '0;
    r.byte_out = b;
    r.region   = REGION_HEADER;
    if (body_len_q == 0) begin
      if (hdr_pos < HDR_STORE_BYTES) hdr_shift = {hdr_shift[55:0], b};
      else if (hdr_pos <= META_LO_IDX) meta_len_q = {meta_len_q[7:0], b};
      if (hdr_pos >= HDR_LEN - 1) begin
        magic = hdr_shift[63:48];
        types = hdr_shift[47:32];
        total = hdr_shift[31:0];
        body  = total - HDR_LEN;
        // The checks rank: magic and type first, then size, then metadata length.
        if (magic != cfg_magic_q || types != 16'h0) begin
          r.error_code = ERR_MAGIC;
        end else if (total < HDR_LEN || body >= cfg_max_body_q) begin
          r.error_code = ERR_OVERSIZE;
        end else if ({16'h0, meta_len_q} > body) begin
          r.error_code = ERR_BAD_LEN;
        end else begin
          r.header_done    = 1'b1;
          r.meta_length    = meta_len_q;
          r.payload_length = body - {16'h0, meta_len_q};
        end
        hdr_pos    = '0;
        body_len_q = '0;
        if (r.header_done) begin
          if (body == 0) r.frame_done = 1'b1;
          else body_len_q = body;
        end
      end else begin
        hdr_pos = hdr_pos + 1;
      end
    end else begin
      r.region = (hdr_pos < {16'h0, meta_len_q}) ? REGION_META : REGION_PAYLOAD;
      if (hdr_pos + 32'd1 >= body_len_q) begin
        r.frame_done = 1'b1;
        hdr_pos      = '0;
        body_len_q   = '0;
      end else begin
        hdr_pos = hdr_pos + 1;
      end
    end
    return r;
  endfunction

  // Monitor: takes register writes and bytes into the predictor and checks each result word.
  always @(posedge clk) begin
    in_fire  = rst_n && in_if.valid && in_if.ready;
    out_fire = rst_n && out_if.valid && out_if.ready;
    if (!rst_n) begin
      cfg_magic_q    = '0;
      cfg_max_body_q = '1;
      hdr_pos        = '0;
      hdr_shift      = '0;
      meta_len_q     = '0;
      body_len_q     = '0;
      predicted_words.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == CFG_MAGIC_WORD) cfg_magic_q = cfg_if.wdata[15:0];
        else if (cfg_if.index == CFG_MAX_BODY_BYTES) cfg_max_body_q = cfg_if.wdata;
      end
      if (in_fire) predicted_words.push_back(deframe_byte(in_if.data_byte));
      if (out_fire) begin
        if (predicted_words.size() == 0) begin
          report_mismatch("result word arrived with no prediction pending");
        end else begin
          want = predicted_words.pop_front();
          check_field("byte_out", out_if.byte_out, want.byte_out);
          check_field("region", out_if.region, want.region);
          check_field("header_done", out_if.header_done, want.header_done);
          check_field("meta_length", out_if.meta_length, want.meta_length);
          check_field("payload_length", out_if.payload_length, want.payload_length);
          check_field("frame_done", out_if.frame_done, want.frame_done);
          check_field("error_code", out_if.error_code, want.error_code);
          frames_done += want.frame_done;
          if (want.error_code == ERR_MAGIC) rej_magic++;
          if (want.error_code == ERR_OVERSIZE) rej_oversize++;
          if (want.error_code == ERR_BAD_LEN) rej_len++;
        end
        words_checked++;
      end
    end
  end

  // Byte driver: holds a word until it is taken, then waits a random gap before the next.
  always @(negedge clk) begin
    if (rst_n && (!in_if.valid || in_fire)) begin
      if (in_gap > 0) begin
        in_if.valid <= 1'b0;
        in_gap = in_gap - 1;
      end else if (byte_stream.size() > 0) begin
        in_if.valid     <= 1'b1;
        in_if.data_byte <= byte_stream.pop_front();
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, 16);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: after each word it holds ready low for a random stall.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire) begin
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_stall = out_calm ? 0 : $urandom_range(0, 16);
      end
      if (out_stall > 0) begin
        out_if.ready <= 1'b0;
        out_stall = out_stall - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b);
    byte_stream.push_back(b);
    bytes_queued++;
  endtask

  // Queues one header and, when it should pass the checks, its body. A header that would
  // open a long body gets a wrong magic word instead, unless long_ok allows a short tail.
  task automatic push_frame(input logic [15:0] magic, input logic [15:0] types,
                            input logic [31:0] total, input logic [15:0] meta,
                            input bit long_ok);
    logic [31:0] body;
    bit          pass;
    body = total - HDR_LEN;
    pass = (magic == cfg_magic_q) && (types == 16'h0) && (total >= HDR_LEN) &&
           (body < cfg_max_body_q) && ({16'h0, meta} <= body);
    if (pass && body > 32'd1024 && !long_ok) begin
      magic = ~cfg_magic_q;
      pass  = 1'b0;
    end
    push_byte(magic[15:8]);
    push_byte(magic[7:0]);
    push_byte(types[15:8]);
    push_byte(types[7:0]);
    push_byte(total[31:24]);
    push_byte(total[23:16]);
    push_byte(total[15:8]);
    push_byte(total[7:0]);
    push_byte(meta[15:8]);
    push_byte(meta[7:0]);
    repeat (HDR_LEN - 10) push_byte($urandom_range(0, 255));
    if (pass) repeat (long_ok ? 24 : body) push_byte($urandom_range(0, 255));
  endtask

  // Mostly good frames with random sizes; the rest are broken headers of each kind.
  task automatic rand_frame();
    int          sel;
    logic [31:0] body;
    logic [31:0] total;
    logic [32:0] wide;
    logic [15:0] magic;
    logic [15:0] types;
    logic [15:0] meta;
    sel   = $urandom_range(0, 99);
    body  = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 40);
    magic = cfg_magic_q;
    types = '0;
    total = body + HDR_LEN;
    meta  = $urandom_range(0, body);
    if (sel >= 96) begin
      magic = $urandom;
      types = $urandom;
      total = $urandom;
      meta  = $urandom;
    end else if (sel >= 92) begin
      wide  = {1'b0, cfg_max_body_q} + HDR_LEN + $urandom_range(0, 1000);
      total = wide[32] ? 32'hFFFF_FFFF : wide[31:0];
    end else if (sel >= 88) begin
      meta = body + $urandom_range(1, 300);
    end else if (sel >= 84) begin
      total = $urandom_range(0, HDR_LEN - 1);
    end else if (sel >= 80) begin
      types = $urandom_range(1, 16'hFFFF);
    end else if (sel >= 76) begin
      magic = magic ^ (16'h1 << $urandom_range(0, 15));
    end
    push_frame(magic, types, total, meta, 1'b0);
  endtask

  // Waits until every queued byte went in and every predicted word came out.
  task automatic wait_drained();
    do @(posedge clk);
    while (byte_stream.size() != 0 || in_if.valid || predicted_words.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] magic, input logic [31:0] max_body,
                           input int nbytes);
    int stop_at;
    write_reg(CFG_MAGIC_WORD, {16'h0, magic});
    write_reg(CFG_MAX_BODY_BYTES, max_body);
    stop_at = bytes_queued + nbytes;
    while (bytes_queued < stop_at) rand_frame();
    wait_drained();
    settings_run++;
  endtask

  initial begin
    logic [15:0] dm;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.wdata    = '0;
    rst_n           = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // A good frame under the values the registers come out of reset with.
    push_frame(16'h0000, 16'h0000, 32'd20, 16'd3, 1'b0);
    wait_drained();
    settings_run++;

    // Directed frames around a body limit of 40 bytes.
    dm = $urandom_range(1, 16'hFFFE);
    write_reg(CFG_MAGIC_WORD, {16'h0, dm});
    write_reg(CFG_MAX_BODY_BYTES, 32'd40);
    push_frame(dm, 16'h0000, 32'd16, 16'd0, 1'b0);             // empty body
    push_frame(dm, 16'h0000, 32'd26, 16'd4, 1'b0);             // metadata then payload
    push_frame(dm, 16'h0000, 32'd55, 16'd39, 1'b0);            // largest body, no payload
    push_frame(dm, 16'h0000, 32'd56, 16'd0, 1'b0);             // body at the limit
    push_frame(dm ^ 16'h8000, 16'h0000, 32'd20, 16'd0, 1'b0);  // wrong magic
    push_frame(dm, 16'h0100, 32'd20, 16'd0, 1'b0);             // type bytes not zero
    push_frame(dm, 16'h0001, 32'd20, 16'd0, 1'b0);
    push_frame(dm, 16'h0000, 32'd15, 16'd0, 1'b0);             // total shorter than header
    push_frame(dm, 16'h0000, 32'd0, 16'd0, 1'b0);
    push_frame(dm, 16'h0000, 32'hFFFF_FFFF, 16'd0, 1'b0);
    push_frame(dm, 16'h0000, 32'd20, 16'd5, 1'b0);             // metadata longer than body
    push_frame(dm, 16'h0000, 32'd16, 16'hFFFF, 1'b0);
    push_frame(~dm, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);  // magic wins over the rest
    push_frame(dm, 16'h0000, 32'd66, 16'hFFFF, 1'b0);          // oversize wins over length
    push_frame(dm, 16'h0000, 32'd52, 16'd0, 1'b0);             // payload only
    wait_drained();

    // Writes to indexes past the register list must leave both registers alone.
    write_reg(8'd2, 32'h0);
    write_reg(8'hFF, $urandom);
    push_frame(dm, 16'h0000, 32'd20, 16'd2, 1'b0);
    push_frame(16'h0000, 16'h0000, 32'd20, 16'd2, 1'b0);
    wait_drained();
    settings_run++;

    // Random frames under several settings, the extremes of the body limit among them.
    run_phase($urandom_range(0, 16'hFFFF), 32'hFFFF_FFFF, 200);
    run_phase(16'hFFFF, 32'd1, 200);
    run_phase(16'h0000, 32'd0, 200);
    run_phase($urandom_range(0, 16'hFFFF), $urandom_range(8, 48), 200);
    run_phase($urandom_range(0, 16'hFFFF), $urandom_range(20, 60), 200);

    // The largest header that still passes; the body stays open at the end of the run.
    write_reg(CFG_MAX_BODY_BYTES, 32'hFFFF_FFFF);
    push_frame(cfg_magic_q, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    wait_drained();
    repeat (20) @(posedge clk);
    if (predicted_words.size() != 0)
      report_mismatch($sformatf("%0d predicted words never arrived", predicted_words.size()));

    $display("Checked %0d result words over %0d register settings, %0d frames completed.",
             words_checked, settings_run + 1, frames_done);
    $display("Headers rejected: %0d magic or type, %0d oversize, %0d bad length.",
             rej_magic, rej_oversize, rej_len);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_TU);
    $display("Timeout: %0d words still predicted, %0d bytes unsent.",
             predicted_words.size(), byte_stream.size());
    $display("tb NOT OK");
    $finish;
  end

endmodule
